// ===== hdl/sspe_pkg.sv =====
package sspe_pkg;

    typedef enum logic [1:0] {
        REQ_DRAW  = 2'd0,
        REQ_ERASE = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAW,
        ST_SCAN,
        ST_WAIT,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_q;     // capture request, clear index and result
        logic clear_cnt;  // empty the store
        logic wr_draw;    // append query segment, count up
        logic res_draw;   // result box = query box
        logic set_full;   // flag dropped draw
        logic rd_idx;     // read entry at scan index, start pipeline
        logic rd_last;    // read last stored entry
        logic wr_move;    // write last entry over scan index
        logic hit_take;   // merge box, count down
        logic miss_take;  // step scan index
        logic finish;     // present result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic scan_end;
        logic hit_valid;
        logic hit;
    } t_stat;

endpackage

// ===== hdl/sspe_ctrl.sv =====
module sspe_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic [1:0]         i_req_type,
    input  sspe_pkg::t_stat    i_stat,
    output sspe_pkg::t_cmd     o_cmd,
    output logic               busy
);

    sspe_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sspe_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sspe_pkg::ST_IDLE: begin
                if (start) begin
                    unique case (sspe_pkg::t_req'(i_req_type))
                        sspe_pkg::REQ_DRAW:  n_state = sspe_pkg::ST_DRAW;
                        sspe_pkg::REQ_ERASE: n_state = sspe_pkg::ST_SCAN;
                        default:             n_state = sspe_pkg::ST_FINISH;
                    endcase
                end
            end
            sspe_pkg::ST_DRAW:    n_state = sspe_pkg::ST_FINISH;
            sspe_pkg::ST_SCAN: begin
                n_state = i_stat.scan_end ? sspe_pkg::ST_FINISH : sspe_pkg::ST_WAIT;
            end
            sspe_pkg::ST_WAIT: begin
                if (i_stat.hit_valid) begin
                    n_state = i_stat.hit ? sspe_pkg::ST_MOVE_RD : sspe_pkg::ST_SCAN;
                end
            end
            sspe_pkg::ST_MOVE_RD: n_state = sspe_pkg::ST_MOVE_WR;
            sspe_pkg::ST_MOVE_WR: n_state = sspe_pkg::ST_SCAN;
            sspe_pkg::ST_FINISH:  n_state = sspe_pkg::ST_IDLE;
            default:              n_state = sspe_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            sspe_pkg::ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load_q    = 1'b1;
                    o_cmd.clear_cnt = (sspe_pkg::t_req'(i_req_type) == sspe_pkg::REQ_CLEAR);
                end
            end
            sspe_pkg::ST_DRAW: begin
                if (i_stat.full) begin
                    o_cmd.set_full = 1'b1;
                end else begin
                    o_cmd.wr_draw  = 1'b1;
                    o_cmd.res_draw = 1'b1;
                end
            end
            sspe_pkg::ST_SCAN: begin
                o_cmd.rd_idx = !i_stat.scan_end;
            end
            sspe_pkg::ST_WAIT: begin
                o_cmd.hit_take  = i_stat.hit_valid && i_stat.hit;
                o_cmd.miss_take = i_stat.hit_valid && !i_stat.hit;
            end
            sspe_pkg::ST_MOVE_RD: o_cmd.rd_last = 1'b1;
            sspe_pkg::ST_MOVE_WR: o_cmd.wr_move = 1'b1;
            sspe_pkg::ST_FINISH:  o_cmd.finish  = 1'b1;
            default:              busy = 1'b1;
        endcase
    end

endmodule

// ===== hdl/sspe_dp.sv =====
module sspe_dp #(
    parameter int MAX_SEGMENTS = 256,
    parameter int COORD_BITS   = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sspe_pkg::t_cmd               i_cmd,
    output sspe_pkg::t_stat              o_stat,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  logic [7:0]                   i_pen_width,
    output logic                         o_done,
    output logic                         o_box_valid,
    output logic signed [COORD_BITS:0]   o_box_left,
    output logic signed [COORD_BITS:0]   o_box_top,
    output logic signed [COORD_BITS:0]   o_box_right,
    output logic signed [COORD_BITS:0]   o_box_bottom,
    output logic                         o_store_full,
    output logic [8:0]                   o_removed_count
);

    localparam int CB   = COORD_BITS;
    localparam int DW   = CB + 1;
    localparam int MW   = 2 * DW;
    localparam int PW   = MW + 1;
    localparam int PW2  = 2 * PW;
    localparam int H    = (PW + 1) / 2;
    localparam int CH   = PW - H;
    localparam int BW   = ((CB > 10) ? CB : 10) + 2;
    localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
    localparam int AW   = $clog2(MAX_SEGMENTS);
    localparam int EW   = 4 * CB + 8;
    localparam int LAT  = 7;

    typedef struct packed {
        logic signed [BW-1:0] l;
        logic signed [BW-1:0] t;
        logic signed [BW-1:0] r;
        logic signed [BW-1:0] b;
    } t_box;

    function automatic t_box mk_box(input logic signed [CB-1:0] ax, input logic signed [CB-1:0] ay,
                                    input logic signed [CB-1:0] bx, input logic signed [CB-1:0] by,
                                    input logic [7:0] w);
        t_box                 bx_o;
        logic signed [BW-1:0] g;
        logic signed [BW-1:0] eax, eay, ebx, eby;
        g   = signed'(BW'({w, 1'b0}));
        eax = BW'(ax);
        eay = BW'(ay);
        ebx = BW'(bx);
        eby = BW'(by);
        bx_o.l = ((eax < ebx) ? eax : ebx) - g;
        bx_o.r = ((eax > ebx) ? eax : ebx) + g;
        bx_o.t = ((eay < eby) ? eay : eby) - g;
        bx_o.b = ((eay > eby) ? eay : eby) + g;
        return bx_o;
    endfunction

    // request
    logic signed [CB-1:0] r_qax, r_qay, r_qbx, r_qby;
    logic [7:0]           r_qw;
    t_box                 qb;
    logic signed [CB-1:0] px [2];
    logic signed [CB-1:0] py [2];

    // store
    logic [EW-1:0]   mem [MAX_SEGMENTS];
    logic [EW-1:0]   r_rd;
    logic [CNTW-1:0] r_cnt, r_idx;
    logic [LAT-1:0]  r_vld;

    logic signed [CB-1:0] eax, eay, ebx, eby;
    logic [7:0]           ew;
    t_box                 sb;

    // result accumulation
    t_box            r_acc;
    logic            r_acc_v, r_full;
    logic [CNTW-1:0] r_rem;

    // distance pipeline
    logic signed [DW-1:0] r1_dx, r1_dy;
    logic signed [DW-1:0] r1_qx [2];
    logic signed [DW-1:0] r1_qy [2];
    logic signed [DW-1:0] r1_ex [2];
    logic signed [DW-1:0] r1_ey [2];
    logic [15:0]          r1_r2;
    t_box                 r1_sb;
    logic                 r1_ov;

    logic signed [MW-1:0] r2_dxx, r2_dyy;
    logic signed [MW-1:0] r2_qdx [2];
    logic signed [MW-1:0] r2_qdy [2];
    logic signed [MW-1:0] r2_qqx [2];
    logic signed [MW-1:0] r2_qqy [2];
    logic signed [MW-1:0] r2_eex [2];
    logic signed [MW-1:0] r2_eey [2];
    logic signed [MW-1:0] r2_cx  [2];
    logic signed [MW-1:0] r2_cy  [2];

    logic signed [PW-1:0] r3_len;
    logic signed [PW-1:0] r3_dot [2];
    logic signed [PW-1:0] r3_dq  [2];
    logic signed [PW-1:0] r3_de  [2];
    logic [PW-1:0]        r3_c   [2];

    logic [2*CH-1:0]    r4_hh  [2];
    logic [CH+H-1:0]    r4_hl  [2];
    logic [2*H-1:0]     r4_ll  [2];
    logic [16+CH-1:0]   r4_rlh;
    logic [16+H-1:0]    r4_rll;
    logic               r4_z   [2];
    logic               r4_b   [2];
    logic               r4_sok [2];
    logic               r4_eok [2];

    logic [PW2-1:0] r5_c2 [2];
    logic [PW2-1:0] r5_rl;
    logic           r5_z   [2];
    logic           r5_b   [2];
    logic           r5_sok [2];
    logic           r5_eok [2];

    logic r6_hit;
    logic near [2];

    assign qb    = mk_box(r_qax, r_qay, r_qbx, r_qby, r_qw);
    assign px[0] = r_qax;
    assign py[0] = r_qay;
    assign px[1] = r_qbx;
    assign py[1] = r_qby;

    assign eax = signed'(r_rd[EW-1 -: CB]);
    assign eay = signed'(r_rd[EW-CB-1 -: CB]);
    assign ebx = signed'(r_rd[EW-2*CB-1 -: CB]);
    assign eby = signed'(r_rd[EW-3*CB-1 -: CB]);
    assign ew  = r_rd[7:0];
    assign sb  = mk_box(eax, eay, ebx, eby, ew);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_q) begin
            r_qax <= i_start_x;
            r_qay <= i_start_y;
            r_qbx <= i_end_x;
            r_qby <= i_end_y;
            r_qw  <= i_pen_width;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_draw) begin
            mem[r_cnt[AW-1:0]] <= {r_qax, r_qay, r_qbx, r_qby, r_qw};
        end else if (i_cmd.wr_move) begin
            mem[r_idx[AW-1:0]] <= r_rd;
        end
        if (i_cmd.rd_idx) begin
            r_rd <= mem[r_idx[AW-1:0]];
        end else if (i_cmd.rd_last) begin
            r_rd <= mem[r_cnt[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_cmd.rd_idx};
            if (i_cmd.clear_cnt) begin
                r_cnt <= '0;
            end else if (i_cmd.wr_draw) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_cmd.hit_take) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (i_cmd.load_q) begin
                r_idx <= '0;
            end else if (i_cmd.miss_take) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // stage 1: differences, boxes
    always_ff @(posedge i_clk) begin
        r1_dx <= DW'(ebx) - DW'(eax);
        r1_dy <= DW'(eby) - DW'(eay);
        for (int p = 0; p < 2; p++) begin
            r1_qx[p] <= DW'(px[p]) - DW'(eax);
            r1_qy[p] <= DW'(py[p]) - DW'(eay);
            r1_ex[p] <= DW'(px[p]) - DW'(ebx);
            r1_ey[p] <= DW'(py[p]) - DW'(eby);
        end
        r1_r2 <= 16'(r_qw) * 16'(r_qw);
        r1_sb <= sb;
        r1_ov <= !(qb.l > sb.r || sb.l > qb.r || qb.t > sb.b || sb.t > qb.b);
    end

    // stage 2: products
    always_ff @(posedge i_clk) begin
        r2_dxx <= MW'(r1_dx) * MW'(r1_dx);
        r2_dyy <= MW'(r1_dy) * MW'(r1_dy);
        for (int p = 0; p < 2; p++) begin
            r2_qdx[p] <= MW'(r1_qx[p]) * MW'(r1_dx);
            r2_qdy[p] <= MW'(r1_qy[p]) * MW'(r1_dy);
            r2_qqx[p] <= MW'(r1_qx[p]) * MW'(r1_qx[p]);
            r2_qqy[p] <= MW'(r1_qy[p]) * MW'(r1_qy[p]);
            r2_eex[p] <= MW'(r1_ex[p]) * MW'(r1_ex[p]);
            r2_eey[p] <= MW'(r1_ey[p]) * MW'(r1_ey[p]);
            r2_cx[p]  <= MW'(r1_dx) * MW'(r1_qy[p]);
            r2_cy[p]  <= MW'(r1_dy) * MW'(r1_qx[p]);
        end
    end

    // stage 3: sums, cross magnitude
    always_ff @(posedge i_clk) begin
        logic signed [PW-1:0] cr;
        r3_len <= PW'(r2_dxx) + PW'(r2_dyy);
        for (int p = 0; p < 2; p++) begin
            cr         = PW'(r2_cx[p]) - PW'(r2_cy[p]);
            r3_dot[p] <= PW'(r2_qdx[p]) + PW'(r2_qdy[p]);
            r3_dq[p]  <= PW'(r2_qqx[p]) + PW'(r2_qqy[p]);
            r3_de[p]  <= PW'(r2_eex[p]) + PW'(r2_eey[p]);
            r3_c[p]   <= cr[PW-1] ? unsigned'(-cr) : unsigned'(cr);
        end
    end

    // stage 4: split wide products, region flags
    always_ff @(posedge i_clk) begin
        r4_rlh <= (16+CH)'(r1_r2) * (16+CH)'(unsigned'(r3_len[PW-1:H]));
        r4_rll <= (16+H)'(r1_r2) * (16+H)'(unsigned'(r3_len[H-1:0]));
        for (int p = 0; p < 2; p++) begin
            r4_hh[p]  <= (2*CH)'(r3_c[p][PW-1:H]) * (2*CH)'(r3_c[p][PW-1:H]);
            r4_hl[p]  <= (CH+H)'(r3_c[p][PW-1:H]) * (CH+H)'(r3_c[p][H-1:0]);
            r4_ll[p]  <= (2*H)'(r3_c[p][H-1:0]) * (2*H)'(r3_c[p][H-1:0]);
            r4_z[p]   <= (r3_len == '0) || r3_dot[p][PW-1] || (r3_dot[p] == '0);
            r4_b[p]   <= (r3_dot[p] >= r3_len);
            r4_sok[p] <= (unsigned'(r3_dq[p]) <= PW'(r1_r2));
            r4_eok[p] <= (unsigned'(r3_de[p]) <= PW'(r1_r2));
        end
    end

    // stage 5: recombine cross^2 and r^2 * len
    always_ff @(posedge i_clk) begin
        r5_rl <= (PW2'(r4_rlh) << H) + PW2'(r4_rll);
        for (int p = 0; p < 2; p++) begin
            r5_c2[p]  <= (PW2'(r4_hh[p]) << (2*H)) + (PW2'(r4_hl[p]) << (H+1))
                         + PW2'(r4_ll[p]);
            r5_z[p]   <= r4_z[p];
            r5_b[p]   <= r4_b[p];
            r5_sok[p] <= r4_sok[p];
            r5_eok[p] <= r4_eok[p];
        end
    end

    // stage 6: decision
    always_comb begin
        for (int p = 0; p < 2; p++) begin
            near[p] = r5_z[p] ? r5_sok[p] : (r5_b[p] ? r5_eok[p] : (r5_c2[p] <= r5_rl));
        end
    end

    always_ff @(posedge i_clk) begin
        r6_hit <= r1_ov && (near[0] || near[1]);
    end

    assign o_stat.full      = (r_cnt >= CNTW'(MAX_SEGMENTS));
    assign o_stat.scan_end  = (r_idx >= r_cnt);
    assign o_stat.hit_valid = r_vld[LAT-1];
    assign o_stat.hit       = r6_hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_q) begin
            r_acc   <= '0;
            r_acc_v <= 1'b0;
            r_full  <= 1'b0;
            r_rem   <= '0;
        end else begin
            if (i_cmd.res_draw) begin
                r_acc   <= qb;
                r_acc_v <= 1'b1;
            end
            if (i_cmd.set_full) begin
                r_full <= 1'b1;
            end
            if (i_cmd.hit_take) begin
                r_acc_v <= 1'b1;
                r_rem   <= r_rem + 1'b1;
                if (!r_acc_v) begin
                    r_acc <= r1_sb;
                end else begin
                    r_acc.l <= (r1_sb.l < r_acc.l) ? r1_sb.l : r_acc.l;
                    r_acc.t <= (r1_sb.t < r_acc.t) ? r1_sb.t : r_acc.t;
                    r_acc.r <= (r1_sb.r > r_acc.r) ? r1_sb.r : r_acc.r;
                    r_acc.b <= (r1_sb.b > r_acc.b) ? r1_sb.b : r_acc.b;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_box_valid     <= r_acc_v;
            o_box_left      <= r_acc.l[CB:0];
            o_box_top       <= r_acc.t[CB:0];
            o_box_right     <= r_acc.r[CB:0];
            o_box_bottom    <= r_acc.b[CB:0];
            o_store_full    <= r_full;
            o_removed_count <= 9'(r_rem);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNTW'(MAX_SEGMENTS))
        else $error("segment count above capacity");

    a_hit_timed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hit_take |-> r_vld[LAT-1] && r6_hit)
        else $error("removal without a finished distance check");

    a_draw_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_draw |-> r_cnt < CNTW'(MAX_SEGMENTS))
        else $error("draw written into full store");

    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hit_take |=> r_rem == $past(r_rem) + 1'b1)
        else $error("removed count did not step");

endmodule

// ===== hdl/segment_store_proximity_erase_top.sv =====
// Segment store with proximity erase.
// Request channel: drive i_req_type, the endpoints and i_pen_width with start
// high; the item is taken at the clock edge where start is high and busy low.
// Request codes: draw stores the segment and returns its box (extent grown
// by twice the pen width), or sets o_store_full when the store is full;
// erase removes every stored segment whose box overlaps the eraser box and
// that lies within the eraser radius of either eraser endpoint, and returns
// the union box and count of what it removed; clear empties the store.
// Result channel: o_done is high for exactly one cycle with all result
// fields valid. The receiver cannot stall; it must sample in that cycle.
// Draw passes through the draw state and then the finish state; clear and
// unknown requests go straight to finish; o_done is registered from finish.
// Erase checks the stored entries one at a time: each check is one
// registered memory read followed by the distance pipeline, and a removal
// adds a read and a write to move the last entry into the freed slot, which
// is then checked in turn.
// One request is in work at a time; busy is low again in the o_done cycle,
// so the next item can be taken at the edge that ends it.
// Reset empties the store (count only; memory contents are not cleared).
module segment_store_proximity_erase_top #(
    parameter int MAX_SEGMENTS = 256,
    parameter int COORD_BITS   = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_req_type,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  logic [7:0]                   i_pen_width,
    output logic                         o_done,
    output logic                         o_box_valid,
    output logic signed [COORD_BITS:0]   o_box_left,
    output logic signed [COORD_BITS:0]   o_box_top,
    output logic signed [COORD_BITS:0]   o_box_right,
    output logic signed [COORD_BITS:0]   o_box_bottom,
    output logic                         o_store_full,
    output logic [8:0]                   o_removed_count
);

    sspe_pkg::t_cmd  cmd;   // sequencing commands
    sspe_pkg::t_stat stat;  // store and compare status

    // sequencer: request decode, scan loop, removal moves
    sspe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .busy       (busy)
    );

    // store, distance pipeline and result registers
    sspe_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .i_pen_width     (i_pen_width),
        .o_done          (o_done),
        .o_box_valid     (o_box_valid),
        .o_box_left      (o_box_left),
        .o_box_top       (o_box_top),
        .o_box_right     (o_box_right),
        .o_box_bottom    (o_box_bottom),
        .o_store_full    (o_store_full),
        .o_removed_count (o_removed_count)
    );

endmodule

// ===== sim/segment_store_checker.sv =====
`timescale 1ns / 1ps

module segment_store_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         i_req_type,
    input  logic signed [15:0] i_start_x,
    input  logic signed [15:0] i_start_y,
    input  logic signed [15:0] i_end_x,
    input  logic signed [15:0] i_end_y,
    input  logic [7:0]         i_pen_width,
    input  logic               o_done,
    input  logic               o_box_valid,
    input  logic signed [16:0] o_box_left,
    input  logic signed [16:0] o_box_top,
    input  logic signed [16:0] o_box_right,
    input  logic signed [16:0] o_box_bottom,
    input  logic               o_store_full,
    input  logic [8:0]         o_removed_count,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int DEPTH = 256;

    typedef struct {
        logic              valid;
        logic signed [16:0] l, t, r, b;
        logic              full;
        logic [8:0]        removed;
    } t_box_result;

    typedef struct {
        longint ax, ay, bx, by;
    } t_seg;

    typedef struct {
        longint l, t, r, b;
    } t_rect;

    t_seg        stored_seg [DEPTH];
    logic [7:0]  stored_width [DEPTH];
    int          stored_count;
    t_box_result expected_boxes [$];
    int          fails;
    int          pending_cnt;

    assign o_fail_count = fails;
    assign o_pending    = pending_cnt;

    function automatic t_rect seg_box(t_seg s, int w);
        t_rect  rb;
        longint g;
        g    = 2 * w;
        rb.l = ((s.ax < s.bx) ? s.ax : s.bx) - g;
        rb.r = ((s.ax > s.bx) ? s.ax : s.bx) + g;
        rb.t = ((s.ay < s.by) ? s.ay : s.by) - g;
        rb.b = ((s.ay > s.by) ? s.ay : s.by) + g;
        return rb;
    endfunction

    // squared distance point to segment <= rad^2, exact
    function automatic bit within_reach(t_seg s, longint px, longint py, int rad);
        longint       dx, dy, qx, qy, len, r2, dot, cr, ex, ey;
        logic [127:0] lhs, rhs, c;
        dx  = s.bx - s.ax;
        dy  = s.by - s.ay;
        qx  = px - s.ax;
        qy  = py - s.ay;
        len = dx * dx + dy * dy;
        r2  = longint'(rad) * rad;
        dot = qx * dx + qy * dy;
        if (len == 0 || dot <= 0)
            return (qx * qx + qy * qy) <= r2;
        if (dot >= len) begin
            ex = px - s.bx;
            ey = py - s.by;
            return (ex * ex + ey * ey) <= r2;
        end
        cr  = dx * qy - dy * qx;
        c   = (cr < 0) ? 128'(-cr) : 128'(cr);
        lhs = c * c;
        rhs = 128'(r2) * 128'(len);
        return lhs <= rhs;
    endfunction

    task automatic predict_request(sspe_pkg::t_req req, t_seg q, int w);
        t_box_result res;
        t_rect       eb, sb, acc;
        int          i;
        res   = '{valid: 0, l: 0, t: 0, r: 0, b: 0, full: 0, removed: 0};
        acc   = '{0, 0, 0, 0};
        case (req)
            sspe_pkg::REQ_DRAW: begin
                if (stored_count >= DEPTH) begin
                    res.full = 1;
                end else begin
                    stored_seg[stored_count]   = q;
                    stored_width[stored_count] = 8'(w);
                    stored_count++;
                    acc       = seg_box(q, w);
                    res.valid = 1;
                end
            end
            sspe_pkg::REQ_ERASE: begin
                eb = seg_box(q, w);
                i  = 0;
                while (i < stored_count) begin
                    sb = seg_box(stored_seg[i], stored_width[i]);
                    if (!(eb.l > sb.r || sb.l > eb.r || eb.t > sb.b || sb.t > eb.b) &&
                        (within_reach(stored_seg[i], q.ax, q.ay, w) ||
                         within_reach(stored_seg[i], q.bx, q.by, w))) begin
                        if (!res.valid) begin
                            acc       = sb;
                            res.valid = 1;
                        end else begin
                            if (sb.l < acc.l) acc.l = sb.l;
                            if (sb.t < acc.t) acc.t = sb.t;
                            if (sb.r > acc.r) acc.r = sb.r;
                            if (sb.b > acc.b) acc.b = sb.b;
                        end
                        res.removed++;
                        stored_count--;
                        // last entry fills the hole, examined next
                        stored_seg[i]   = stored_seg[stored_count];
                        stored_width[i] = stored_width[stored_count];
                    end else begin
                        i++;
                    end
                end
            end
            sspe_pkg::REQ_CLEAR: stored_count = 0;
            default: ;
        endcase
        if (res.valid) begin
            res.l = acc.l[16:0];
            res.t = acc.t[16:0];
            res.r = acc.r[16:0];
            res.b = acc.b[16:0];
        end
        expected_boxes = {expected_boxes, res};
    endtask

    always @(posedge i_clk) begin
        t_box_result exp_box;
        t_seg        q;
        if (!i_rst_n) begin
            stored_count = 0;
            fails        = 0;
            expected_boxes.delete();
        end else begin
            if (start && !busy) begin
                q.ax = i_start_x;
                q.ay = i_start_y;
                q.bx = i_end_x;
                q.by = i_end_y;
                predict_request(sspe_pkg::t_req'(i_req_type), q, i_pen_width);
            end
            if (o_done) begin
                if (expected_boxes.size() == 0) begin
                    $error("result with nothing expected");
                    fails++;
                end else begin
                    exp_box = expected_boxes.pop_front();
                    if (o_box_valid !== exp_box.valid) begin
                        $error("box_valid exp %0d got %0d", exp_box.valid, o_box_valid);
                        fails++;
                    end
                    if (o_box_left !== exp_box.l) begin
                        $error("box_left exp %0d got %0d", exp_box.l, o_box_left);
                        fails++;
                    end
                    if (o_box_top !== exp_box.t) begin
                        $error("box_top exp %0d got %0d", exp_box.t, o_box_top);
                        fails++;
                    end
                    if (o_box_right !== exp_box.r) begin
                        $error("box_right exp %0d got %0d", exp_box.r, o_box_right);
                        fails++;
                    end
                    if (o_box_bottom !== exp_box.b) begin
                        $error("box_bottom exp %0d got %0d", exp_box.b, o_box_bottom);
                        fails++;
                    end
                    if (o_store_full !== exp_box.full) begin
                        $error("store_full exp %0d got %0d", exp_box.full, o_store_full);
                        fails++;
                    end
                    if (o_removed_count !== exp_box.removed) begin
                        $error("removed_count exp %0d got %0d",
                               exp_box.removed, o_removed_count);
                        fails++;
                    end
                end
            end
        end
        pending_cnt = expected_boxes.size();
    end

endmodule

// ===== sim/tb_segment_store_proximity_erase_top.sv =====
`timescale 1ns / 1ps

module tb_segment_store_proximity_erase_top;

    localparam int ITEM_TARGET = 1650;
    localparam int QUIET_TAIL  = 200;   // last items go back to back

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               start = 0;
    logic               busy;
    logic [1:0]         i_req_type = sspe_pkg::REQ_NONE;
    logic signed [15:0] i_start_x = 0, i_start_y = 0, i_end_x = 0, i_end_y = 0;
    logic [7:0]         i_pen_width = 0;
    logic               o_done, o_box_valid, o_store_full;
    logic signed [16:0] o_box_left, o_box_top, o_box_right, o_box_bottom;
    logic [8:0]         o_removed_count;
    int                 fail_count, pending;
    int                 items_sent = 0;

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    segment_store_proximity_erase_top dut (.*);

    segment_store_checker u_checker (
        .*,
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Present one item and hold it until the edge that takes it.
    // busy only moves at posedge, so the value seen at negedge is the
    // value at the next edge.
    task automatic issue_request(sspe_pkg::t_req req, int sx, int sy, int ex, int ey,
                                 int w);
        bit was_busy;
        start       <= 1'b1;
        i_req_type  <= req;
        i_start_x   <= 16'(sx);
        i_start_y   <= 16'(sy);
        i_end_x     <= 16'(ex);
        i_end_y     <= 16'(ey);
        i_pen_width <= 8'(w);
        do begin
            @(negedge i_clk);
            was_busy = busy;
            @(posedge i_clk);
        end while (was_busy);
        items_sent++;
        // random idle burst on the request side, none near the end
        if (items_sent < ITEM_TARGET - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // point jittered around a center, saturated to 16 bits
    function automatic int jitter(int c, int spread);
        int v;
        v = c + $signed($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767)  v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    function automatic int any_coord();
        return $signed(16'($urandom));
    endfunction

    initial begin
        int cx, cy, spread, n_draw, n_erase, k;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes and each special case
        issue_request(sspe_pkg::REQ_ERASE, 0, 0, 0, 0, 255);       // erase on empty store
        issue_request(sspe_pkg::REQ_DRAW, -32768, -32768, 32767, 32767, 255);
        issue_request(sspe_pkg::REQ_DRAW, 32767, 32767, -32768, -32768, 0);
        issue_request(sspe_pkg::REQ_DRAW, 0, 0, 0, 0, 0);          // degenerate segment
        issue_request(sspe_pkg::REQ_DRAW, 100, 0, 200, 0, 3);
        issue_request(sspe_pkg::REQ_ERASE, 500, 500, 600, 600, 0); // removes both long diagonals
        issue_request(sspe_pkg::REQ_ERASE, 0, 0, 0, 0, 0);         // exact hit on a point
        issue_request(sspe_pkg::REQ_ERASE, 150, 5, 150, 5, 5);     // interior projection, edge
        issue_request(sspe_pkg::REQ_ERASE, 150, 6, 150, 6, 5);     // store is already empty here
        issue_request(sspe_pkg::REQ_NONE, 1, 2, 3, 4, 5);          // unknown request
        issue_request(sspe_pkg::REQ_ERASE, -32768, -32768, -32768, -32768, 255);
        issue_request(sspe_pkg::REQ_DRAW, 10, 10, 20, 20, 1);
        issue_request(sspe_pkg::REQ_CLEAR, 0, 0, 0, 0, 0);
        issue_request(sspe_pkg::REQ_ERASE, 10, 10, 20, 20, 255);   // after clear

        // fill the store, overflow it, then wipe all in one erase
        for (k = 0; k < 256; k++)
            issue_request(sspe_pkg::REQ_DRAW, jitter(0, 2), jitter(0, 2), jitter(0, 2),
                          jitter(0, 2), $urandom_range(0, 255));
        issue_request(sspe_pkg::REQ_DRAW, 1, 1, 1, 1, 1);
        issue_request(sspe_pkg::REQ_ERASE, 0, 0, 0, 0, 10);

        // random phase with an optional clear, then draw bursts around a spot and erases near it
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 1) == 0)
                issue_request(sspe_pkg::REQ_CLEAR, any_coord(), any_coord(), any_coord(),
                              any_coord(), $urandom_range(0, 255));
            cx      = any_coord();
            cy      = any_coord();
            spread  = ($urandom_range(0, 3) == 0) ? 2000 : $urandom_range(1, 60);
            n_draw  = $urandom_range(1, 12);
            n_erase = $urandom_range(1, 3);
            for (k = 0; k < n_draw; k++)
                issue_request(sspe_pkg::REQ_DRAW, jitter(cx, spread), jitter(cy, spread),
                              jitter(cx, spread), jitter(cy, spread),
                              $urandom_range(0, 255));
            for (k = 0; k < n_erase; k++)
                issue_request(sspe_pkg::REQ_ERASE, jitter(cx, spread), jitter(cy, spread),
                              jitter(cx, spread), jitter(cy, spread),
                              $urandom_range(0, 255));
            // noise: any request type with full-range fields
            if ($urandom_range(0, 4) == 0)
                issue_request(sspe_pkg::t_req'($urandom_range(0, 3)), any_coord(),
                              any_coord(), any_coord(), any_coord(),
                              $urandom_range(0, 255));
        end
        start <= 1'b0;
        // let the checker log the last accepted item before polling
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #100ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== segment_store_proximity_erase_top.f =====
hdl/sspe_pkg.sv
hdl/sspe_ctrl.sv
hdl/sspe_dp.sv
hdl/segment_store_proximity_erase_top.sv
sim/segment_store_checker.sv
sim/tb_segment_store_proximity_erase_top.sv
